@@ sv/mvb_pkg.sv @@
// ----------------------------------------------------------------------------
// mvb_pkg
// Shared types, constants and the CRC-16/MCRF4XX byte update for the
// MAVLink 1.0 frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mvb_pkg;

	// Default depth of the queue between front and back
	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0]  StartByte = 8'hFE;
	localparam logic [15:0] CrcSeed   = 16'hFFFF;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_PAYLOAD_LEN   = 3'd0,
		REG_SYSTEM_ID     = 3'd1,
		REG_COMPONENT_ID  = 3'd2,
		REG_MESSAGE_ID    = 3'd3,
		REG_CRC_EXTRA     = 3'd4
	} reg_idx_t;

	// Configuration seen by front and back
	typedef struct packed {
		logic [7:0] payload_len;
		logic [7:0] system_id;
		logic [7:0] component_id;
		logic [7:0] message_id;
		logic [7:0] crc_seed_extra;
	} cfg_t;

	// One classified payload byte waiting in the queue
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} beat_t;

	// Fold one byte into the running CRC (X.25 / MCRF4XX, no final xor)
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] t;
		t = b ^ crc[7:0];
		t = t ^ {t[3:0], 4'b0000};
		return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
	endfunction

endpackage

`default_nettype wire

@@ sv/mvb_front.sv @@
// ----------------------------------------------------------------------------
// mvb_front
// Accepts payload bytes, tracks the position in the frame and tags each
// byte as first and/or last of its frame before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mvb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,      // [7:0] payload_byte
	input  wire logic [7:0]    payload_len,
	input  wire logic          q_full,
	output logic               push,
	output mvb_pkg::beat_t     push_beat
);

	logic [7:0] pos_q;
	logic [7:0] pos_next;
	logic       is_last;

	// Accept whenever the queue has room
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// Classify the beat by its place in the frame
	assign pos_next        = pos_q + 8'd1;
	assign is_last         = (pos_next == payload_len);
	assign push_beat.data  = s_tdata;
	assign push_beat.first = (pos_q == 8'd0);
	assign push_beat.last  = is_last;

	// Advance the payload counter, restart after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 8'd0;
		end else if (push) begin
			pos_q <= is_last ? 8'd0 : pos_next;
		end
	end

endmodule

`default_nettype wire

@@ sv/mvb_queue.sv @@
// ----------------------------------------------------------------------------
// mvb_queue
// Short first-in first-out queue of classified beats between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mvb_queue #(
	parameter int unsigned DEPTH = mvb_pkg::QueueDepth
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mvb_pkg::beat_t push_beat,
	input  wire logic           pop,
	output mvb_pkg::beat_t      head,
	output logic                empty,
	output logic                full
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	mvb_pkg::beat_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign empty = (count_q == CW'(0));
	assign full  = (count_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	// Store incoming beats
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/mvb_back.sv @@
// ----------------------------------------------------------------------------
// mvb_back
// Serializes queued beats into the frame byte stream: header ahead of the
// first payload byte, CRC low and high bytes after the last one.
// ----------------------------------------------------------------------------
`default_nettype none

module mvb_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mvb_pkg::cfg_t  cfg,
	input  wire logic           q_empty,
	input  wire mvb_pkg::beat_t q_head,
	output logic                pop,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [7:0]          m_tdata,     // [7:0] frame_byte
	output logic                m_tlast      // end_of_frame
);

	typedef enum logic [3:0] {
		ST_FETCH,
		ST_LEN,
		ST_SEQ,
		ST_SYS,
		ST_COMP,
		ST_MSG,
		ST_PAY,
		ST_CRC_LO,
		ST_CRC_HI
	} state_t;

	state_t         state_q, state_n;
	mvb_pkg::beat_t cur_q, cur_n;
	logic [15:0]    crc_q, crc_n, crc_x;
	logic [7:0]     seq_q, seq_n;
	logic           tvalid_q, tlast_q;
	logic [7:0]     tdata_q;
	logic           ld;
	logic           emit, elast, feed;
	logic [7:0]     ebyte;

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	// Load a new byte when the output register is empty or being taken
	assign ld    = !tvalid_q || m_tready;
	assign crc_x = mvb_pkg::crc_feed(crc_q, cfg.crc_seed_extra);

	// Pick the next byte of the frame
	always_comb begin
		state_n = state_q;
		cur_n   = cur_q;
		seq_n   = seq_q;
		crc_n   = crc_q;
		pop     = 1'b0;
		emit    = 1'b0;
		elast   = 1'b0;
		feed    = 1'b0;
		ebyte   = cur_q.data;
		if (ld) begin
			unique case (state_q)
				ST_FETCH: begin
					if (!q_empty) begin
						pop   = 1'b1;
						cur_n = q_head;
						emit  = 1'b1;
						if (q_head.first) begin
							ebyte   = mvb_pkg::StartByte;
							crc_n   = mvb_pkg::CrcSeed;
							state_n = ST_LEN;
						end else begin
							ebyte   = q_head.data;
							feed    = 1'b1;
							state_n = q_head.last ? ST_CRC_LO : ST_FETCH;
						end
					end
				end
				ST_LEN: begin
					emit    = 1'b1;
					ebyte   = cfg.payload_len;
					feed    = 1'b1;
					state_n = ST_SEQ;
				end
				ST_SEQ: begin
					emit    = 1'b1;
					ebyte   = seq_q;
					feed    = 1'b1;
					state_n = ST_SYS;
				end
				ST_SYS: begin
					emit    = 1'b1;
					ebyte   = cfg.system_id;
					feed    = 1'b1;
					state_n = ST_COMP;
				end
				ST_COMP: begin
					emit    = 1'b1;
					ebyte   = cfg.component_id;
					feed    = 1'b1;
					state_n = ST_MSG;
				end
				ST_MSG: begin
					emit    = 1'b1;
					ebyte   = cfg.message_id;
					feed    = 1'b1;
					seq_n   = seq_q + 8'd1;
					state_n = ST_PAY;
				end
				ST_PAY: begin
					emit    = 1'b1;
					ebyte   = cur_q.data;
					feed    = 1'b1;
					state_n = cur_q.last ? ST_CRC_LO : ST_FETCH;
				end
				ST_CRC_LO: begin
					emit    = 1'b1;
					ebyte   = crc_x[7:0];
					crc_n   = crc_x;
					state_n = ST_CRC_HI;
				end
				ST_CRC_HI: begin
					emit    = 1'b1;
					ebyte   = crc_q[15:8];
					elast   = 1'b1;
					crc_n   = mvb_pkg::CrcSeed;
					state_n = ST_FETCH;
				end
				default: begin
					state_n = ST_FETCH;
				end
			endcase
			if (feed) begin
				crc_n = mvb_pkg::crc_feed(crc_q, ebyte);
			end
		end
	end

	// Hold sequencer state and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_FETCH;
			crc_q    <= mvb_pkg::CrcSeed;
			seq_q    <= 8'd0;
			tvalid_q <= 1'b0;
			tlast_q  <= 1'b0;
			tdata_q  <= 8'd0;
			cur_q    <= '0;
		end else begin
			state_q <= state_n;
			crc_q   <= crc_n;
			seq_q   <= seq_n;
			cur_q   <= cur_n;
			if (ld) begin
				tvalid_q <= emit;
				tdata_q  <= ebyte;
				tlast_q  <= elast;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/mavlink_v1_frame_builder.sv @@
// ----------------------------------------------------------------------------
// mavlink_v1_frame_builder
// MAVLink 1.0 framer: payload bytes in, framed byte stream with CRC out.
// ----------------------------------------------------------------------------
// Mid-frame, one payload byte goes in and one frame byte comes out per cycle
// while the output is not stalled. The back sequencer sends the start byte
// and five header bytes before the first payload byte of a frame and two CRC
// bytes after the last; it loads one byte into the output register per cycle
// while that register is empty or being taken. A queue of QUEUE_DEPTH beats
// lets the input keep taking bytes while the header or CRC is being sent.
// Registers sit at byte addresses 0x00 payload_len, 0x04 system_id,
// 0x08 component_id, 0x0C message_id, 0x10 crc_seed_extra; write them only
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module mavlink_v1_frame_builder #(
	parameter int unsigned QUEUE_DEPTH = mvb_pkg::QueueDepth
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// payload in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] payload_byte
	// frame out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,    // [7:0] frame_byte
	output logic             m_tlast     // end_of_frame
);

	mvb_pkg::cfg_t     cfg_q;
	mvb_pkg::reg_idx_t reg_idx;
	mvb_pkg::beat_t    push_beat, q_head;
	logic              push, pop, q_empty, q_full;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = mvb_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.payload_len    <= 8'd9;
			cfg_q.system_id      <= 8'd51;
			cfg_q.component_id   <= 8'd68;
			cfg_q.message_id     <= 8'd109;
			cfg_q.crc_seed_extra <= 8'd185;
		end else if (wr_en) begin
			unique case (reg_idx)
				mvb_pkg::REG_PAYLOAD_LEN:  cfg_q.payload_len    <= pwdata[7:0];
				mvb_pkg::REG_SYSTEM_ID:    cfg_q.system_id      <= pwdata[7:0];
				mvb_pkg::REG_COMPONENT_ID: cfg_q.component_id   <= pwdata[7:0];
				mvb_pkg::REG_MESSAGE_ID:   cfg_q.message_id     <= pwdata[7:0];
				mvb_pkg::REG_CRC_EXTRA:    cfg_q.crc_seed_extra <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (reg_idx)
			mvb_pkg::REG_PAYLOAD_LEN:  prdata = {24'd0, cfg_q.payload_len};
			mvb_pkg::REG_SYSTEM_ID:    prdata = {24'd0, cfg_q.system_id};
			mvb_pkg::REG_COMPONENT_ID: prdata = {24'd0, cfg_q.component_id};
			mvb_pkg::REG_MESSAGE_ID:   prdata = {24'd0, cfg_q.message_id};
			mvb_pkg::REG_CRC_EXTRA:    prdata = {24'd0, cfg_q.crc_seed_extra};
			default:                   prdata = 32'd0;
		endcase
	end

	mvb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.payload_len (cfg_q.payload_len),
		.q_full      (q_full),
		.push        (push),
		.push_beat   (push_beat)
	);

	mvb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	mvb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_head   (q_head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

@@ sv/mvb_checker.sv @@
// ----------------------------------------------------------------------------
// mvb_checker
// Port-level checks on the frame builder, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module mvb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast
);

	logic frame_start_q;

	// Track whether the next output beat opens a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_start_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			frame_start_q <= m_tlast;
		end
	end

	// Stalled output beat holds its contents
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Every frame opens with the start byte and is never a one-byte frame
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && frame_start_q |-> m_tdata == mvb_pkg::StartByte && !m_tlast)
		else $error("frame does not open with the start byte");

	// Input may only back up while output has a byte pending
	a_ready_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

endmodule

bind mavlink_v1_frame_builder mvb_checker u_mvb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

@@ sim/mvb_stream_check.sv @@
// ----------------------------------------------------------------------------
// mvb_stream_check
// Watches the payload, frame and register channels of the MAVLink 1.0 frame
// builder, predicts every frame byte from a private copy of the registers
// and framing state, and compares each accepted frame beat with the oldest
// expected byte. Mismatches and unexpected beats are counted.
// ----------------------------------------------------------------------------
`default_nettype none

module mvb_stream_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] payload_byte
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,    // [7:0] frame_byte
	input  wire logic        m_tlast,    // end_of_frame
	output int unsigned      bytes_due,
	output int unsigned      mismatches
);

	// Reflected form of the CCITT polynomial used by X.25 / MCRF4XX
	localparam logic [15:0] PolyReflected = 16'h8408;

	typedef struct packed {
		logic [7:0] data;
		logic       eof;
	} frame_beat_t;

	frame_beat_t due_q[$];

	mvb_pkg::cfg_t shadow;
	logic [7:0]    seq_num;
	logic [15:0]   crc_acc;
	logic [7:0]    pay_pos;

	// Bitwise CRC update, LSB first
	function automatic logic [15:0] mcrf4xx_fold(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		int i;
		r = c ^ {8'h00, b};
		for (i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ PolyReflected) : (r >> 1);
		end
		return r;
	endfunction

	task automatic emit_byte(input logic [7:0] b, input logic eof, input bit fold);
		frame_beat_t fb;
		fb.data = b;
		fb.eof  = eof;
		due_q.push_back(fb);
		if (fold) begin
			crc_acc = mcrf4xx_fold(crc_acc, b);
		end
	endtask

	// Queue the frame bytes caused by one payload beat
	task automatic predict_frame_bytes(input logic [7:0] b);
		logic [15:0] fin;
		if (pay_pos == 8'd0) begin
			crc_acc = mvb_pkg::CrcSeed;
			emit_byte(mvb_pkg::StartByte, 1'b0, 1'b0);
			emit_byte(shadow.payload_len, 1'b0, 1'b1);
			emit_byte(seq_num, 1'b0, 1'b1);
			emit_byte(shadow.system_id, 1'b0, 1'b1);
			emit_byte(shadow.component_id, 1'b0, 1'b1);
			emit_byte(shadow.message_id, 1'b0, 1'b1);
			seq_num = seq_num + 8'd1;
		end
		emit_byte(b, 1'b0, 1'b1);
		pay_pos = pay_pos + 8'd1;
		// close the frame once the counter meets the current length
		if (pay_pos == shadow.payload_len) begin
			fin = mcrf4xx_fold(crc_acc, shadow.crc_seed_extra);
			emit_byte(fin[7:0], 1'b0, 1'b0);
			emit_byte(fin[15:8], 1'b1, 1'b0);
			crc_acc = mvb_pkg::CrcSeed;
			pay_pos = 8'd0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_beat_t want;
		if (!arst_n) begin
			shadow.payload_len    = 8'd9;
			shadow.system_id      = 8'd51;
			shadow.component_id   = 8'd68;
			shadow.message_id     = 8'd109;
			shadow.crc_seed_extra = 8'd185;
			seq_num    = 8'd0;
			crc_acc    = mvb_pkg::CrcSeed;
			pay_pos    = 8'd0;
			mismatches = 0;
			due_q.delete();
			bytes_due <= 0;
		end else begin
			// compare the frame beat with the oldest expectation
			if (m_tvalid && m_tready) begin
				if (due_q.size() == 0) begin
					mismatches = mismatches + 1;
					$error("frame_byte: expected nothing, got %02h", m_tdata);
				end else begin
					want = due_q.pop_front();
					if (m_tdata !== want.data) begin
						mismatches = mismatches + 1;
						$error("frame_byte: expected %02h, got %02h", want.data, m_tdata);
					end
					if (m_tlast !== want.eof) begin
						mismatches = mismatches + 1;
						$error("end_of_frame: expected %0d, got %0d", want.eof, m_tlast);
					end
				end
			end
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (mvb_pkg::reg_idx_t'(paddr[4:2]))
					mvb_pkg::REG_PAYLOAD_LEN:  shadow.payload_len    = pwdata[7:0];
					mvb_pkg::REG_SYSTEM_ID:    shadow.system_id      = pwdata[7:0];
					mvb_pkg::REG_COMPONENT_ID: shadow.component_id   = pwdata[7:0];
					mvb_pkg::REG_MESSAGE_ID:   shadow.message_id     = pwdata[7:0];
					mvb_pkg::REG_CRC_EXTRA:    shadow.crc_seed_extra = pwdata[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predict_frame_bytes(s_tdata);
			end
			bytes_due <= due_q.size();
		end
	end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the MAVLink 1.0 frame builder. Runs a directed
// pass over register and payload extremes and mid-frame register changes,
// then random phases with fresh settings, random gaps on both streams and
// one long output stall. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	localparam int unsigned QuietLimit = 2000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = '0;
	logic        m_tready = 1'b0;
	wire  logic [31:0] prdata;
	wire  logic        pready;
	wire  logic        s_tready;
	wire  logic        m_tvalid;
	wire  logic [7:0]  m_tdata;
	wire  logic        m_tlast;

	int unsigned bytes_due;
	int unsigned mismatches;
	int unsigned quiet     = 0;

	// stimulus-side frame tracking, used only to pick safe lengths, plus gap and stall controls
	logic [7:0] cur_len   = 8'd9;
	logic [7:0] frame_pos = 8'd0;
	bit         steady    = 1'b0;
	bit         hold_req  = 1'b0;

	always #6 clk = ~clk;

	mavlink_v1_frame_builder DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	mvb_stream_check frame_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.bytes_due(bytes_due), .mismatches(mismatches)
	);

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
		if (quiet >= QuietLimit) begin
			$display("mavlink_v1_frame_builder: mismatch");
			$finish;
		end
	end

	// Frame sink: random ready pattern, one long hold-off when requested
	initial begin : sink
		int span;
		bit held;
		bit level;
		held  = 1'b0;
		level = 1'b0;
		span  = 0;
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held  = 1'b1;
				level = 1'b0;
				span  = 0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			if (span == 0) begin
				level = !level;
				if (level) begin
					span = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 60)
						: $urandom_range(30, 1);
				end else begin
					span = ($urandom_range(9, 0) == 0) ? $urandom_range(50, 15)
						: $urandom_range(3, 1);
				end
				m_tready <= level;
			end
			span = span - 1;
			@(posedge clk);
		end
	end

	function automatic int idle_span();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 65) begin
			return 0;
		end else if (r < 95) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 8);
	endfunction

	// Register value with a bias toward the extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(3, 0))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one payload beat and hold it until accepted
	task automatic push_payload(input logic [7:0] b);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		frame_pos = frame_pos + 8'd1;
		if (frame_pos == cur_len) begin
			frame_pos = 8'd0;
		end
		gap = idle_span();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Leaves the bus selected so back-to-back writes chain without a gap
	task automatic write_reg(input mvb_pkg::reg_idx_t idx, input logic [7:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'h000000, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == mvb_pkg::REG_PAYLOAD_LEN) begin
			cur_len = val;
		end
	endtask

	task automatic bus_release();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stop offering and wait until every expected frame byte has left
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		int p;
		int n_items;
		int lo;
		int hi;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// one frame at reset settings, payload extremes
		push_payload(8'h00);
		push_payload(8'hFF);
		push_payload(8'h55);
		push_payload(8'hAA);
		push_payload(8'h01);
		push_payload(8'h80);
		push_payload(8'h7F);
		push_payload(8'hFE);
		push_payload(8'h0F);
		drain();

		// shortest frames, sequence advances per frame
		write_reg(mvb_pkg::REG_PAYLOAD_LEN, 8'd1);
		write_reg(mvb_pkg::REG_SYSTEM_ID, 8'h00);
		write_reg(mvb_pkg::REG_COMPONENT_ID, 8'hFF);
		write_reg(mvb_pkg::REG_MESSAGE_ID, 8'h00);
		write_reg(mvb_pkg::REG_CRC_EXTRA, 8'hFF);
		bus_release();
		push_payload(8'hFF);
		push_payload(8'h00);
		drain();

		// zero length header, then shorten mid-frame before the count passes it
		write_reg(mvb_pkg::REG_PAYLOAD_LEN, 8'd0);
		write_reg(mvb_pkg::REG_SYSTEM_ID, 8'hFF);
		write_reg(mvb_pkg::REG_COMPONENT_ID, 8'h00);
		write_reg(mvb_pkg::REG_MESSAGE_ID, 8'hFF);
		write_reg(mvb_pkg::REG_CRC_EXTRA, 8'h00);
		bus_release();
		push_payload(8'hF0);
		push_payload(8'h0F);
		push_payload(8'hFE);
		drain();
		// header change mid-frame shows up only in the next header
		write_reg(mvb_pkg::REG_PAYLOAD_LEN, 8'd5);
		write_reg(mvb_pkg::REG_SYSTEM_ID, 8'h12);
		bus_release();
		push_payload(8'h33);
		push_payload(8'hCC);
		push_payload(8'h01);
		push_payload(8'h02);
		push_payload(8'h04);
		push_payload(8'h08);
		push_payload(8'h10);
		drain();

		// longest length, then shorten mid-frame to a length not yet reached
		write_reg(mvb_pkg::REG_PAYLOAD_LEN, 8'd255);
		bus_release();
		repeat (20) push_payload(8'($urandom));
		drain();
		write_reg(mvb_pkg::REG_PAYLOAD_LEN, 8'd24);
		write_reg(mvb_pkg::REG_CRC_EXTRA, pick_byte());
		bus_release();
		repeat (4) push_payload(8'($urandom));
		drain();

		// short-frame phases with fresh settings, one under a long output stall
		for (p = 0; p < 8; p++) begin
			lo = int'(frame_pos) + 1;
			hi = (lo > 12) ? lo : 12;
			steady = ($urandom_range(3, 0) == 0);
			write_reg(mvb_pkg::REG_PAYLOAD_LEN, 8'($urandom_range(hi, lo)));
			if ($urandom_range(1, 0) != 0) begin
				write_reg(mvb_pkg::REG_SYSTEM_ID, pick_byte());
			end
			if ($urandom_range(1, 0) != 0) begin
				write_reg(mvb_pkg::REG_COMPONENT_ID, pick_byte());
			end
			if ($urandom_range(1, 0) != 0) begin
				write_reg(mvb_pkg::REG_MESSAGE_ID, pick_byte());
			end
			write_reg(mvb_pkg::REG_CRC_EXTRA, pick_byte());
			bus_release();
			n_items = (p == 2) ? 24 : $urandom_range(30, 10);
			if (p == 2) begin
				hold_req = 1'b1;
			end
			repeat (n_items) push_payload(8'($urandom));
			drain();
		end

		// let any stray beats surface, then decide
		repeat (20) @(posedge clk);
		if (mismatches == 0 && bytes_due == 0) begin
			$display("mavlink_v1_frame_builder: match");
		end else begin
			$display("mavlink_v1_frame_builder: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
